@@ sv/mmn_pkg.sv @@
// Shared constants and types for the min-max normalizer.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mmn_pkg;

    // sizing of the sample store and the sample word
    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_BITS   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_BITS    = $clog2(MAX_SAMPLES + 1);

    // fixed result field widths
    localparam int LEVEL_BITS  = 16;
    localparam int POS_BITS    = 6;
    localparam int STEP_BITS   = $clog2(LEVEL_BITS + 1);

    // request into the iterative divider
    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] dividend;
        logic [SAMPLE_BITS-1:0] divisor;
    } t_div_req;

    // answer from the iterative divider
    typedef struct packed {
        logic                  done;
        logic [LEVEL_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ sv/mmn_store.sv @@
// Sample store: one write port, one read port with registered read data.
// Depends on mmn_pkg for depth and word width.
`timescale 1ns / 1ps
`default_nettype none

module mmn_store (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [mmn_pkg::ADDR_BITS-1:0]       i_waddr,
    input  wire logic [mmn_pkg::SAMPLE_BITS-1:0]     i_wdata,
    input  wire logic [mmn_pkg::ADDR_BITS-1:0]       i_raddr,
    output      logic [mmn_pkg::SAMPLE_BITS-1:0]     o_rdata
);

    logic [mmn_pkg::SAMPLE_BITS-1:0] r_mem [mmn_pkg::MAX_SAMPLES];
    logic [mmn_pkg::SAMPLE_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/mmn_div.sv @@
// Restoring divider producing a saturated Q0.16 ratio dividend / divisor.
// Depends on mmn_pkg for widths and the request/answer structs.
`timescale 1ns / 1ps
`default_nettype none

module mmn_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mmn_pkg::t_div_req i_req,
    output      mmn_pkg::t_div_rsp o_rsp
);

    logic                                r_run;
    logic [mmn_pkg::STEP_BITS-1:0]       r_cnt;
    logic [mmn_pkg::SAMPLE_BITS-1:0]     r_rem;
    logic [mmn_pkg::SAMPLE_BITS-1:0]     r_dvs;
    logic [mmn_pkg::LEVEL_BITS-1:0]      r_quo;
    logic                                r_sat;
    logic                                r_zero;

    logic [mmn_pkg::SAMPLE_BITS:0]       w_shift;
    logic                                w_ge;
    logic [mmn_pkg::SAMPLE_BITS:0]       w_diff;

    // one quotient bit per cycle
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_run <= 1'b1;
            r_cnt <= mmn_pkg::STEP_BITS'(mmn_pkg::LEVEL_BITS);
        end else if (r_run) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    // datapath: dividend never exceeds divisor, so the remainder stays narrow
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.dividend;
            r_dvs  <= i_req.divisor;
            r_quo  <= '0;
            r_zero <= (i_req.divisor == '0);
            r_sat  <= (i_req.dividend == i_req.divisor);
        end else if (r_run && (r_cnt != '0)) begin
            r_rem <= w_ge ? w_diff[mmn_pkg::SAMPLE_BITS-1:0] : w_shift[mmn_pkg::SAMPLE_BITS-1:0];
            r_quo <= {r_quo[mmn_pkg::LEVEL_BITS-2:0], w_ge};
        end
    end

    // flat range gives zero, exact full scale saturates
    always_comb begin
        o_rsp.done = r_run && (r_cnt == '0);
        if (r_zero) begin
            o_rsp.quotient = '0;
        end else if (r_sat) begin
            o_rsp.quotient = '1;
        end else begin
            o_rsp.quotient = r_quo;
        end
    end

endmodule

`default_nettype wire

@@ sv/min_max_normalizer.sv @@
// Min-max normalizer: loading a block of samples, then draining it normalized.
// The block takes one sample item per cycle while loading (busy low). The item
// with i_last set starts the drain: busy goes high and every stored sample comes
// out in arrival order as (sample - min) / (max - min), unsigned Q0.16 with full
// scale held at 65535. Each result takes a store read, a subtract, sixteen steps
// of the shared restoring divider and a result step, in that order. Results are
// held for one cycle under o_strobe and cannot be stalled. At most 64 samples
// are kept; later ones are dropped and flagged on every result of that block.
// Depends on mmn_pkg, mmn_store and mmn_div.
`timescale 1ns / 1ps
`default_nettype none

module min_max_normalizer (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output      logic                                  busy,
    input  wire logic signed [mmn_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                  i_last,
    output      logic                                  o_strobe,
    output      logic [mmn_pkg::LEVEL_BITS-1:0]        o_level,
    output      logic [mmn_pkg::POS_BITS-1:0]          o_position,
    output      logic                                  o_dropped,
    output      logic                                  o_final_res
);

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_READ = 4'b0010,
        S_SUB  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    localparam logic signed [mmn_pkg::SAMPLE_BITS-1:0] MinInit =
        {1'b0, {(mmn_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [mmn_pkg::SAMPLE_BITS-1:0] MaxInit =
        {1'b1, {(mmn_pkg::SAMPLE_BITS-1){1'b0}}};

    t_state                                    r_state, n_state;
    logic signed [mmn_pkg::SAMPLE_BITS-1:0]    r_min, n_min;
    logic signed [mmn_pkg::SAMPLE_BITS-1:0]    r_max, n_max;
    logic [mmn_pkg::CNT_BITS-1:0]              r_count, n_count;
    logic                                      r_ovf, n_ovf;
    logic [mmn_pkg::ADDR_BITS-1:0]             r_idx, n_idx;
    logic                                      r_strobe, n_strobe;
    logic [mmn_pkg::LEVEL_BITS-1:0]            r_level, n_level;
    logic [mmn_pkg::POS_BITS-1:0]              r_position, n_position;
    logic                                      r_dropped, n_dropped;
    logic                                      r_final, n_final;

    logic                                      w_accept;
    logic                                      w_room;
    logic                                      w_we;
    logic [mmn_pkg::SAMPLE_BITS-1:0]           w_rdata;
    logic [mmn_pkg::SAMPLE_BITS:0]             w_offset;
    logic [mmn_pkg::SAMPLE_BITS:0]             w_span;
    logic                                      w_is_end;
    mmn_pkg::t_div_req                         w_req;
    mmn_pkg::t_div_rsp                         w_rsp;

    // loading and draining never overlap, busy is the interlock on the store
    assign busy     = (r_state != S_LOAD);
    assign w_accept = start && !busy;
    assign w_room   = (r_count < mmn_pkg::CNT_BITS'(mmn_pkg::MAX_SAMPLES));
    assign w_we     = w_accept && w_room;

    mmn_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[mmn_pkg::ADDR_BITS-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // offset and range, both non-negative
    always_comb begin
        w_offset = {w_rdata[mmn_pkg::SAMPLE_BITS-1], w_rdata} -
                   {r_min[mmn_pkg::SAMPLE_BITS-1], r_min};
        w_span   = {r_max[mmn_pkg::SAMPLE_BITS-1], r_max} -
                   {r_min[mmn_pkg::SAMPLE_BITS-1], r_min};
        w_is_end = ((mmn_pkg::CNT_BITS'(r_idx) + mmn_pkg::CNT_BITS'(1)) == r_count);
        w_req.start    = (r_state == S_SUB);
        w_req.dividend = w_offset[mmn_pkg::SAMPLE_BITS-1:0];
        w_req.divisor  = w_span[mmn_pkg::SAMPLE_BITS-1:0];
    end

    mmn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // sequencer: load, then read / subtract / divide per stored sample
    always_comb begin
        n_state    = r_state;
        n_min      = r_min;
        n_max      = r_max;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_idx      = r_idx;
        n_strobe   = 1'b0;
        n_level    = r_level;
        n_position = r_position;
        n_dropped  = r_dropped;
        n_final    = r_final;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_count = r_count + 1'b1;
                        if (i_sample < r_min) begin
                            n_min = i_sample;
                        end
                        if (i_sample > r_max) begin
                            n_max = i_sample;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_idx   = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_SUB;
            end
            S_SUB: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_strobe   = 1'b1;
                    n_level    = w_rsp.quotient;
                    n_position = mmn_pkg::POS_BITS'(r_idx);
                    n_dropped  = r_ovf;
                    n_final    = w_is_end;
                    if (w_is_end) begin
                        n_min   = MinInit;
                        n_max   = MaxInit;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_min    <= MinInit;
            r_max    <= MaxInit;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_min    <= n_min;
            r_max    <= n_max;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        r_level    <= n_level;
        r_position <= n_position;
        r_dropped  <= n_dropped;
        r_final    <= n_final;
    end

    assign o_strobe    = r_strobe;
    assign o_level     = r_level;
    assign o_position  = r_position;
    assign o_dropped   = r_dropped;
    assign o_final_res = r_final;

    // a result only follows a divide that finished
    a_strobe_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DIV))
        else $error("result strobe without a finished divide");

    // divider answers only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // the fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mmn_pkg::CNT_BITS'(mmn_pkg::MAX_SAMPLES))
        else $error("fill count beyond store depth");

    // the final result hands the block back to loading with a clean state
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_final_res) |-> (!busy && (r_count == '0) && !r_ovf))
        else $error("block not cleared after final result");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for min_max_normalizer: random and directed sample blocks,
// checked against a scoreboard that predicts each normalized result.
// Depends on mmn_pkg and min_max_normalizer.
`timescale 1ns / 1ps

module testbench;

    localparam int SMP_W       = mmn_pkg::SAMPLE_BITS;
    localparam int CAPACITY    = mmn_pkg::MAX_SAMPLES;
    localparam int LEVEL_W     = mmn_pkg::LEVEL_BITS;
    localparam int POS_W       = mmn_pkg::POS_BITS;
    localparam int LEVEL_FULL  = (1 << LEVEL_W) - 1;
    localparam int ITEM_TARGET = 380;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 60;

    // one normalized result as seen on the ports
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   position;
        logic               dropped;
        logic               final_res;
    } t_norm_result;

    // predicts the normalized results of each block and checks them in order
    class t_norm_scoreboard;
        logic signed [SMP_W-1:0] held [CAPACITY];
        logic signed [SMP_W-1:0] lo_val;
        logic signed [SMP_W-1:0] hi_val;
        int unsigned             held_count;
        bit                      overflow;
        t_norm_result            due [$];
        int unsigned             mismatches;

        function new();
            mismatches = 0;
            clear_block();
        endfunction

        function void clear_block();
            lo_val     = {1'b0, {(SMP_W-1){1'b1}}};
            hi_val     = {1'b1, {(SMP_W-1){1'b0}}};
            held_count = 0;
            overflow   = 1'b0;
        endfunction

        function logic [LEVEL_W-1:0] scale(logic signed [SMP_W-1:0] smp);
            longint span;
            longint quot;
            if (hi_val <= lo_val) return '0;
            span = longint'(hi_val) - longint'(lo_val);
            quot = ((longint'(smp) - longint'(lo_val)) << LEVEL_W) / span;
            if (quot > LEVEL_FULL) quot = LEVEL_FULL;
            return quot[LEVEL_W-1:0];
        endfunction

        // accepted sample item: store it, and on last queue the whole block
        function void note_input(logic signed [SMP_W-1:0] smp, logic lst);
            t_norm_result r;
            if (held_count < CAPACITY) begin
                held[held_count] = smp;
                held_count++;
                if (smp < lo_val) lo_val = smp;
                if (smp > hi_val) hi_val = smp;
            end else begin
                overflow = 1'b1;
            end
            if (!lst) return;
            for (int k = 0; k < held_count; k++) begin
                r.level     = scale(held[k]);
                r.position  = k[POS_W-1:0];
                r.dropped   = overflow;
                r.final_res = (k + 1 == held_count);
                due.push_back(r);
            end
            clear_block();
        endfunction

        function void report(string what, t_norm_result want, t_norm_result got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected level=%0d pos=%0d drop=%0b last=%0b,",
                         $time, what, want.level, want.position, want.dropped,
                         want.final_res,
                         "  got level=%0d pos=%0d drop=%0b last=%0b",
                         got.level, got.position, got.dropped, got.final_res);
        endfunction

        function void check_result(t_norm_result got);
            t_norm_result want;
            if (due.size() == 0) begin
                report("result with nothing pending", got, got);
                return;
            end
            want = due.pop_front();
            if (got.level !== want.level || got.position !== want.position ||
                got.dropped !== want.dropped || got.final_res !== want.final_res)
                report("result mismatch", want, got);
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic signed [SMP_W-1:0] i_sample = '0;
    logic                    i_last = 1'b0;
    logic                    o_strobe;
    logic [LEVEL_W-1:0]      o_level;
    logic [POS_W-1:0]        o_position;
    logic                    o_dropped;
    logic                    o_final_res;

    t_norm_scoreboard sb = new();
    int unsigned      items_sent = 0;
    int unsigned      idle_pct = 0;
    int unsigned      quiet_cycles = 0;

    min_max_normalizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .o_strobe    (o_strobe),
        .o_level     (o_level),
        .o_position  (o_position),
        .o_dropped   (o_dropped),
        .o_final_res (o_final_res)
    );

    always #5 i_clk = ~i_clk;

    // note accepted items and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_input(i_sample, i_last);
            if (o_strobe)
                sb.check_result(t_norm_result'({o_level, o_position, o_dropped,
                                                o_final_res}));
        end
    end

    // watchdog on cycles with no item and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", STALL_LIMIT);
            $display("FAIL min_max_normalizer");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one item from a falling edge and hold it until accepted
    task automatic send_item(input logic signed [SMP_W-1:0] smp, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            i_sample <= $urandom;
            i_last   <= $urandom_range(1);
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= smp;
        i_last   <= lst;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // hold off until every expected result has come out
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // one random block: length and value spread vary from block to block
    task automatic send_random_block();
        int unsigned             len;
        int unsigned             spread;
        int unsigned             pick;
        logic signed [SMP_W-1:0] base;
        logic signed [SMP_W-1:0] smp;
        pick = $urandom_range(99);
        if (pick < 70)      len = $urandom_range(1, 8);
        else if (pick < 90) len = $urandom_range(9, 40);
        else if (pick < 96) len = CAPACITY;
        else                len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
        spread = $urandom_range(3);
        base   = $urandom;
        for (int k = 0; k < len; k++) begin
            case (spread)
                0: smp = $urandom;
                1: smp = base + $urandom_range(15);
                2: smp = base;
                default: smp = $urandom_range(1) ? {1'b0, {(SMP_W-1){1'b1}}}
                                                 : {1'b1, {(SMP_W-1){1'b0}}};
            endcase
            send_item(smp, k == len - 1);
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // extremes, saturation at full scale, flat and single-sample blocks
        idle_pct = 8;
        send_item(16'sh8000, 1'b0);
        send_item(16'sh7fff, 1'b0);
        send_item(16'sh0000, 1'b0);
        send_item(16'shffff, 1'b0);
        send_item(16'sh0001, 1'b1);
        send_item(16'sd1234, 1'b1);
        send_item(16'sd7, 1'b0);
        send_item(16'sd7, 1'b0);
        send_item(16'sd7, 1'b1);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh8001, 1'b1);
        send_item(16'sd100, 1'b0);
        send_item(16'sd300, 1'b0);
        send_item(16'sd200, 1'b1);
        wait_drained();

        // random blocks, sender busy, then sparse, then back to back
        while (items_sent < ITEM_TARGET / 3) send_random_block();
        wait_drained();
        idle_pct = 77;
        while (items_sent < 2 * ITEM_TARGET / 3) send_random_block();
        wait_drained();
        idle_pct = 0;
        while (items_sent < ITEM_TARGET) send_random_block();
        wait_drained();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS min_max_normalizer");
        end else begin
            $display("FAIL min_max_normalizer");
        end
        $finish;
    end

endmodule
